/* hdl/bpa_pkg.sv */
// Shared constants, codes and types for the bitmap page allocator.
// No dependencies; imported by the allocator top level.
package bpa_pkg;

  localparam int MAX_PAGES  = 1024;
  localparam int WORD_BITS  = 64;
  localparam int WORD_COUNT = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int ADDR_W     = $clog2(WORD_COUNT);
  localparam int PAGE_W     = 10;
  localparam int CNT_W      = 11;
  localparam int STATUS_W   = 2;

  typedef logic [PAGE_W-1:0]    page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [WORD_BITS-1:0] word_t;

  localparam logic KIND_ACQ = 1'b0;
  localparam logic KIND_REL = 1'b1;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_RANGE = 2'd2;
  localparam status_t ST_FREE  = 2'd3;

  localparam cnt_t LIMIT_RESET = cnt_t'(MAX_PAGES);

endpackage

/* hdl/bpa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies; holds the occupancy map words.
module bpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/bitmap_page_allocator.sv */
// Bitmap page allocator, first fit: occupancy map in a word RAM plus a page count.
// Depends on bpa_pkg and bpa_ram.
//
//  channel | dir | handshake          | beat
//  in      | in  | in_valid/in_stall  | kind, rel_page
//  out     | out | out_valid/out_stall| status, granted_page, pages_in_use
//  cfg     | in  | cfg_we             | cfg_data (page limit)
//
// Release and full acquire: one map word is read on accept and checked in the work
// state. Acquire: map words are scanned from word 0 up, one map word read per cycle,
// to the word holding the granted page (0..15). The next accept follows completion.
// Reset: per-word valid flops clear the whole map at once; limit resets to 1024.
// A stalled result beat is held; the next request is accepted meanwhile and its
// completion waits for the result register to free up.
module bitmap_page_allocator (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  bpa_pkg::cnt_t    cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  bpa_pkg::page_t   rel_page,
  output logic             out_valid,
  input  logic             out_stall,
  output bpa_pkg::status_t status,
  output bpa_pkg::page_t   granted_page,
  output bpa_pkg::cnt_t    pages_in_use
);

  import bpa_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WORK = 1'b1;

  logic                state;
  cnt_t                page_limit;
  cnt_t                cnt;
  cnt_t                cnt_next;
  cnt_t                lim_eff;
  logic                req_kind;
  page_t               req_idx;
  logic                req_full;
  logic [ADDR_W:0]     chk_addr;
  logic [ADDR_W:0]     chk_addr_p1;
  logic [WORD_COUNT-1:0] word_vld;
  logic                vld_q;

  logic                accept;
  logic                out_free;
  logic                finish;
  logic                done;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  word_t               rd_data;
  logic                wr_need;
  logic                wr_en;
  word_t               wr_data;

  word_t               word;
  word_t               mask;
  word_t               free_bits;
  cnt_t                base;
  cnt_t                rem;
  logic [BIT_W-1:0]    bit_sel;
  logic [BIT_W-1:0]    rel_bit;
  status_t             res_status;
  page_t               res_page;

  assign accept      = in_valid && !in_stall;
  assign in_stall    = (state != S_IDLE);
  assign out_free    = !out_valid || !out_stall;
  assign done        = (state == S_WORK) && finish && out_free;
  assign wr_en       = done && wr_need;
  assign chk_addr_p1 = chk_addr + 1'b1;
  assign lim_eff     = (page_limit > LIMIT_RESET) ? LIMIT_RESET : page_limit;

  assign rd_en   = accept || ((state == S_WORK) && !finish);
  assign rd_addr = !accept ? chk_addr_p1[ADDR_W-1:0] :
                   (kind == KIND_REL) ? ADDR_W'(rel_page >> BIT_W) : '0;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_map (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (chk_addr[ADDR_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_comb begin
    word      = vld_q ? rd_data : '0;
    base      = CNT_W'({chk_addr, {BIT_W{1'b0}}});
    rem       = lim_eff - base;
    if (rem >= cnt_t'(WORD_BITS)) begin
      mask = '1;
    end else begin
      mask = (word_t'(1) << rem[BIT_W-1:0]) - word_t'(1);
    end
    free_bits = ~word & mask;
    bit_sel   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
    rel_bit    = req_idx[BIT_W-1:0];
    finish     = 1'b0;
    wr_need    = 1'b0;
    wr_data    = word;
    res_status = ST_OK;
    res_page   = '0;
    cnt_next   = cnt;
    if (req_kind == KIND_REL) begin
      finish = 1'b1;
      if ({1'b0, req_idx} >= LIMIT_RESET) begin
        res_status = ST_RANGE;
      end else if (!word[rel_bit]) begin
        res_status = ST_FREE;
      end else begin
        wr_need  = 1'b1;
        wr_data  = word & ~(word_t'(1) << rel_bit);
        cnt_next = cnt - 1'b1;
      end
    end else if (req_full || (base >= lim_eff)) begin
      finish     = 1'b1;
      res_status = ST_FULL;
    end else if (|free_bits) begin
      finish   = 1'b1;
      wr_need  = 1'b1;
      wr_data  = word | (word_t'(1) << bit_sel);
      res_page = PAGE_W'({chk_addr[ADDR_W-1:0], bit_sel});
      cnt_next = cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      page_limit <= LIMIT_RESET;
      cnt        <= '0;
      word_vld   <= '0;
      vld_q      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_limit <= cfg_data;
      end
      if (rd_en) begin
        vld_q <= word_vld[rd_addr];
      end
      if (wr_en) begin
        word_vld[chk_addr[ADDR_W-1:0]] <= 1'b1;
      end
      if (done) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WORK;
          end
        end
        S_WORK: begin
          if (done) begin
            state <= S_IDLE;
            cnt   <= cnt_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= kind;
      req_idx  <= rel_page;
      req_full <= (cnt >= lim_eff);
      chk_addr <= {1'b0, rd_addr};
    end else if ((state == S_WORK) && !finish) begin
      chk_addr <= chk_addr_p1;
    end
    if (done) begin
      status       <= res_status;
      granted_page <= res_page;
      pages_in_use <= cnt_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pages_in_use <= LIMIT_RESET))
    else $error("page count above map size");

  a_grant_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (granted_page == '0))
    else $error("granted page set on a failed request");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en))
    else $error("map read and write in the same cycle");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(cnt) |-> ($past(state) == S_WORK) && ($past(done)))
    else $error("page count changed outside request completion");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    done |=> out_valid)
    else $error("completed request did not produce a result beat");

endmodule
